FILE: hdl/lcts_pkg.sv
// Shared types and constants for the load-cell tare / calibration scaler.
// No dependencies; imported by load_cell_tare_calibrate_scaler.
package lcts_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_AVERAGE = 256;

    localparam int COUNT_W  = 9;
    localparam int MASS_W   = 24;
    localparam int OFFSET_W = 32;
    localparam int GAIN_W   = 32;
    localparam int SUM_W    = 32;
    localparam int THRUST_W = 48;
    localparam int CFG_W    = 32;

    // sample * 256 - offset before clamping, then clamped to +-(2^32 - 1)
    localparam int SCALED_W = ((SAMPLE_BITS + 8) > OFFSET_W) ? (SAMPLE_BITS + 8) : OFFSET_W;
    localparam int DIFF_WIDE_W = SCALED_W + 1;
    localparam int DIFF_W   = 33;
    localparam int ACC_W    = DIFF_W + 1;
    localparam int PROD_W   = ACC_W + GAIN_W;
    localparam int ROUND_W  = PROD_W - 16;

    // shared restoring divider
    localparam int DIV_W      = 40;
    localparam int AVG_STEPS  = 40;
    localparam int GAIN_STEPS = 32;
    localparam int STEP_W     = 6;

    localparam int GRAV_NUM = 981;
    localparam int GRAV_DEN = 100;

    localparam logic [COUNT_W-1:0]         AVG_COUNT_RESET = 9'd16;
    localparam logic [MASS_W-1:0]          MASS_RESET      = 24'd1000;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET    = 32'sd0;
    localparam logic signed [GAIN_W-1:0]   GAIN_RESET      = 32'sd16777216;

    typedef enum logic [1:0] {
        OP_MEASURE = 2'd0,
        OP_TARE    = 2'd1,
        OP_CALIB   = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_MEASURED   = 3'd0,
        STAT_NOT_READY  = 3'd1,
        STAT_AVERAGING  = 3'd2,
        STAT_TARE_DONE  = 3'd3,
        STAT_CALIBRATED = 3'd4,
        STAT_ZERO_DELTA = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_AVERAGE_COUNT = 2'd0,
        REG_CALIB_MASS    = 2'd1,
        REG_OFFSET_PRESET = 2'd2,
        REG_SCALE_PRESET  = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MULT,
        ST_MROUND,
        ST_AVG_PREP,
        ST_DIV_AVG,
        ST_AVG_FIN,
        ST_GAIN_DELTA,
        ST_GAIN_SETUP,
        ST_GAIN_CMP,
        ST_DIV_GAIN,
        ST_GAIN_RND,
        ST_GAIN_FIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t                           op;
        logic                          sample_ready;
        logic signed [SAMPLE_BITS-1:0] raw_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [THRUST_W-1:0] thrust;
        logic                       thrust_valid;
        status_t                    status;
    } out_item_t;

endpackage

FILE: hdl/load_cell_tare_calibrate_scaler.sv
// Load-cell tare / two-point calibration scaler, single module.
// Depends on lcts_pkg (types, formats, codes).
//
// Usage:
//   in_valid/in_stall/in_data carry one sample item (op, ready flag, raw
//   sample). out_valid/out_stall/out_data return exactly one result per item.
//   A transfer happens on a clock edge with valid high and stall low.
//   cfg_write/cfg_index/cfg_data write the four registers; offset and scale
//   presets load the zero offset and gain directly. Write only while idle.
// Processing paths (accept edge to result on out_valid):
//   measure, ready sample: set by the bit-serial multiplier
//     (one gain bit per cycle, 32 steps).
//   not ready / averaging / unused op: dispatched straight to the result.
//   tare completing an average: a 40-step divide for the mean.
//   calibrate completing: a 40-step mean divide, then a 32-step gain
//     divide on the same restoring divider, skipped on zero delta or overflow.
// One item is in flight at a time; in_stall is high from acceptance until
// the result is moved into the output register. The output register lets
// the next item be accepted while the previous result waits on out_stall;
// a finished result waits in place while that register is held by out_stall.
// Reset: offset 0, gain 1.0 (Q8.24), average count 16, mass 1000 g, held
// thrust 0, accumulation cleared, output empty.
module load_cell_tare_calibrate_scaler
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  lcts_pkg::in_item_t       in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output lcts_pkg::out_item_t      out_data,
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic [lcts_pkg::CFG_W-1:0] cfg_data
);
    import lcts_pkg::*;

    state_t state_reg, state_next;

    // item
    op_t                           op_reg, op_next;
    logic                          rdy_reg, rdy_next;
    logic signed [SAMPLE_BITS-1:0] raw_reg, raw_next;

    // configuration and state
    logic [COUNT_W-1:0]         avg_count_reg, avg_count_next;
    logic [MASS_W-1:0]          mass_reg, mass_next;
    logic signed [OFFSET_W-1:0] zero_offset_reg, zero_offset_next;
    logic signed [GAIN_W-1:0]   gain_reg, gain_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]         taken_reg, taken_next;
    logic signed [THRUST_W-1:0] held_reg, held_next;

    // multiplier
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [ACC_W-1:0]  hi_reg, hi_next;
    logic [GAIN_W-1:0]        lo_reg, lo_next;

    // divider
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  den_reg, den_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              sign_reg, sign_next;

    logic signed [OFFSET_W-1:0] avg_reg, avg_next;
    logic signed [DIFF_W-1:0]   delta_reg, delta_next;

    logic    res_valid_reg, res_valid_next;
    status_t res_status_reg, res_status_next;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    // shared combinational terms
    logic                          in_fire;
    logic                          emit_fire;
    logic [COUNT_W-1:0]            n_eff;
    logic [COUNT_W-1:0]            taken_inc;
    logic                          avg_done;
    logic signed [SUM_W:0]         sum_wide;
    logic signed [SUM_W-1:0]       sum_sat;
    logic signed [DIFF_WIDE_W-1:0] diff_wide;
    logic signed [63:0]            diff_64;
    logic signed [DIFF_W-1:0]      diff_clamped;
    logic signed [ACC_W-1:0]       addend;
    logic signed [ACC_W-1:0]       mac;
    logic signed [PROD_W-1:0]      prod_rounded;
    logic signed [ROUND_W-1:0]     thrust_wide;
    logic signed [THRUST_W-1:0]    thrust_sat;
    logic [DIV_W-1:0]              trial;
    logic [DIV_W:0]                trial_sub;
    logic                          trial_ge;
    logic signed [SUM_W:0]         sum_mag;
    logic signed [DIFF_W-1:0]      delta_abs;
    logic [OFFSET_W-1:0]           avg_val;
    logic [GAIN_W-1:0]             gain_val;
    logic                          delta_zero;
    logic                          num_ge_den;
    logic                          round_up;

    localparam logic signed [63:0] DIFF_HIGH = 64'sd4294967295;
    localparam logic signed [63:0] DIFF_LOW  = -64'sd4294967295;
    localparam logic [DIV_W-1:0]   POS_LIMIT = DIV_W'(64'h7FFF_FFFF);
    localparam logic [DIV_W-1:0]   NEG_LIMIT = DIV_W'(64'h8000_0000);
    localparam logic [DIV_W-1:0]   QUO_FULL  = DIV_W'(64'h1_0000_0000);

    assign in_fire   = in_valid && !in_stall;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    // average length, out-of-range counts folded into 1..MAX_AVERAGE
    always_comb
    begin
        if (avg_count_reg == '0)
            n_eff = COUNT_W'(1);
        else if (avg_count_reg > COUNT_W'(MAX_AVERAGE))
            n_eff = COUNT_W'(MAX_AVERAGE);
        else
            n_eff = avg_count_reg;
    end

    assign taken_inc = taken_reg + COUNT_W'(1);
    assign avg_done  = taken_inc >= n_eff;

    always_comb
    begin
        sum_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(raw_reg);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    always_comb
    begin
        diff_wide = DIFF_WIDE_W'(signed'({raw_reg, 8'h00})) - DIFF_WIDE_W'(zero_offset_reg);
        diff_64   = 64'(diff_wide);
        if (diff_64 > DIFF_HIGH)
            diff_clamped = DIFF_HIGH[DIFF_W-1:0];
        else if (diff_64 < DIFF_LOW)
            diff_clamped = DIFF_LOW[DIFF_W-1:0];
        else
            diff_clamped = diff_64[DIFF_W-1:0];
    end

    // multiplier step: top gain bit carries negative weight
    always_comb
    begin
        if (!lo_reg[0])
            addend = '0;
        else if (cnt_reg == STEP_W'(GAIN_W - 1))
            addend = -ACC_W'(diff_reg);
        else
            addend = ACC_W'(diff_reg);
        mac = hi_reg + addend;
    end

    // round half up to Q.16, saturate to 48 bits
    always_comb
    begin
        prod_rounded = signed'({hi_reg, lo_reg}) + PROD_W'(32768);
        thrust_wide  = prod_rounded[PROD_W-1:16];
        if (thrust_wide[ROUND_W-1:THRUST_W-1] == '0
            || thrust_wide[ROUND_W-1:THRUST_W-1] == '1)
            thrust_sat = thrust_wide[THRUST_W-1:0];
        else if (thrust_wide[ROUND_W-1])
            thrust_sat = {1'b1, {(THRUST_W-1){1'b0}}};
        else
            thrust_sat = {1'b0, {(THRUST_W-1){1'b1}}};
    end

    // restoring divider step
    assign trial     = {rem_reg[DIV_W-2:0], dvd_reg[DIV_W-1]};
    assign trial_sub = {1'b0, trial} - {1'b0, den_reg};
    assign trial_ge  = !trial_sub[DIV_W];

    assign sum_mag    = sum_reg[SUM_W-1] ? -(SUM_W+1)'(sum_reg) : (SUM_W+1)'(sum_reg);
    assign delta_abs  = delta_reg[DIFF_W-1] ? -delta_reg : delta_reg;
    assign delta_zero = delta_reg == '0;
    assign num_ge_den = rem_reg >= den_reg;
    assign round_up   = {rem_reg, 1'b0} >= {1'b0, den_reg};

    // signed saturation of a magnitude quotient to 32 bits
    always_comb
    begin
        if (sign_reg)
            avg_val = (quo_reg > NEG_LIMIT) ? NEG_LIMIT[OFFSET_W-1:0] : -quo_reg[OFFSET_W-1:0];
        else
            avg_val = (quo_reg > POS_LIMIT) ? POS_LIMIT[OFFSET_W-1:0] : quo_reg[OFFSET_W-1:0];
        gain_val = avg_val;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (op_reg == OP_MEASURE)
                    state_next = rdy_reg ? ST_MULT : ST_EMIT;
                else if ((op_reg inside {OP_TARE, OP_CALIB}) && rdy_reg && avg_done)
                    state_next = ST_AVG_PREP;
                else
                    state_next = ST_EMIT;
            end
            ST_MULT:
            begin
                if (cnt_reg == STEP_W'(GAIN_W - 1))
                    state_next = ST_MROUND;
            end
            ST_MROUND:   state_next = ST_EMIT;
            ST_AVG_PREP: state_next = ST_DIV_AVG;
            ST_DIV_AVG:
            begin
                if (cnt_reg == STEP_W'(AVG_STEPS - 1))
                    state_next = ST_AVG_FIN;
            end
            ST_AVG_FIN:    state_next = (op_reg == OP_TARE) ? ST_EMIT : ST_GAIN_DELTA;
            ST_GAIN_DELTA: state_next = ST_GAIN_SETUP;
            ST_GAIN_SETUP: state_next = delta_zero ? ST_EMIT : ST_GAIN_CMP;
            ST_GAIN_CMP:   state_next = num_ge_den ? ST_GAIN_FIN : ST_DIV_GAIN;
            ST_DIV_GAIN:
            begin
                if (cnt_reg == STEP_W'(GAIN_STEPS - 1))
                    state_next = ST_GAIN_RND;
            end
            ST_GAIN_RND: state_next = ST_GAIN_FIN;
            ST_GAIN_FIN: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_fire)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        op_next          = op_reg;
        rdy_next         = rdy_reg;
        raw_next         = raw_reg;
        avg_count_next   = avg_count_reg;
        mass_next        = mass_reg;
        zero_offset_next = zero_offset_reg;
        gain_next        = gain_reg;
        sum_next         = sum_reg;
        taken_next       = taken_reg;
        held_next        = held_reg;
        diff_next        = diff_reg;
        hi_next          = hi_reg;
        lo_next          = lo_reg;
        rem_next         = rem_reg;
        dvd_next         = dvd_reg;
        quo_next         = quo_reg;
        den_next         = den_reg;
        cnt_next         = cnt_reg;
        sign_next        = sign_reg;
        avg_next         = avg_reg;
        delta_next       = delta_reg;
        res_valid_next   = res_valid_reg;
        res_status_next  = res_status_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next  = in_data.op;
                    rdy_next = in_data.sample_ready;
                    raw_next = in_data.raw_sample;
                end
            end
            ST_DISPATCH:
            begin
                res_valid_next  = 1'b0;
                res_status_next = STAT_NOT_READY;
                if (op_reg == OP_MEASURE)
                begin
                    sum_next   = '0;
                    taken_next = '0;
                    diff_next  = diff_clamped;
                    hi_next    = '0;
                    lo_next    = gain_reg;
                    cnt_next   = '0;
                end
                else if ((op_reg inside {OP_TARE, OP_CALIB}) && rdy_reg)
                begin
                    sum_next        = sum_sat;
                    taken_next      = avg_done ? '0 : taken_inc;
                    res_status_next = STAT_AVERAGING;
                end
            end
            ST_MULT:
            begin
                hi_next  = {mac[ACC_W-1], mac[ACC_W-1:1]};
                lo_next  = {mac[0], lo_reg[GAIN_W-1:1]};
                cnt_next = cnt_reg + STEP_W'(1);
            end
            ST_MROUND:
            begin
                held_next       = thrust_sat;
                res_valid_next  = 1'b1;
                res_status_next = STAT_MEASURED;
            end
            ST_AVG_PREP:
            begin
                // (|sum| * 256 + n/2) / n, sign restored afterwards
                sign_next = sum_reg[SUM_W-1];
                dvd_next  = {sum_mag[SUM_W-1:0], 8'h00} + DIV_W'(n_eff >> 1);
                den_next  = DIV_W'(n_eff);
                rem_next  = '0;
                quo_next  = '0;
                cnt_next  = '0;
                sum_next  = '0;
            end
            ST_DIV_AVG, ST_DIV_GAIN:
            begin
                rem_next = trial_ge ? trial_sub[DIV_W-1:0] : trial;
                quo_next = {quo_reg[DIV_W-2:0], trial_ge};
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
                cnt_next = cnt_reg + STEP_W'(1);
            end
            ST_AVG_FIN:
            begin
                if (op_reg == OP_TARE)
                begin
                    zero_offset_next = avg_val;
                    res_status_next  = STAT_TARE_DONE;
                end
                else
                begin
                    avg_next = avg_val;
                end
            end
            ST_GAIN_DELTA:
            begin
                delta_next = DIFF_W'(avg_reg) - DIFF_W'(zero_offset_reg);
            end
            ST_GAIN_SETUP:
            begin
                res_status_next = STAT_ZERO_DELTA;
                // fraction mass*9.81 / |delta|, 32 quotient bits
                sign_next = delta_reg[DIFF_W-1];
                den_next  = DIV_W'(unsigned'(delta_abs)) * DIV_W'(GRAV_DEN);
                rem_next  = DIV_W'(mass_reg) * DIV_W'(GRAV_NUM);
                dvd_next  = '0;
                quo_next  = '0;
                cnt_next  = '0;
            end
            ST_GAIN_CMP:
            begin
                if (num_ge_den)
                    quo_next = QUO_FULL;
            end
            ST_GAIN_RND:
            begin
                quo_next = DIV_W'(quo_reg[GAIN_W-1:0]) + DIV_W'(round_up);
            end
            ST_GAIN_FIN:
            begin
                gain_next       = gain_val;
                res_status_next = STAT_CALIBRATED;
            end
            ST_EMIT:
            begin
            end
            default:
            begin
            end
        endcase

        if (cfg_write)
        begin
            case (cfg_index)
                REG_AVERAGE_COUNT: avg_count_next   = cfg_data[COUNT_W-1:0];
                REG_CALIB_MASS:    mass_next        = cfg_data[MASS_W-1:0];
                REG_OFFSET_PRESET: zero_offset_next = cfg_data[OFFSET_W-1:0];
                REG_SCALE_PRESET:  gain_next        = cfg_data[GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (emit_fire)
        begin
            out_valid_next             = 1'b1;
            out_data_next.thrust       = held_reg;
            out_data_next.thrust_valid = res_valid_reg;
            out_data_next.status       = res_status_reg;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            avg_count_reg   <= AVG_COUNT_RESET;
            mass_reg        <= MASS_RESET;
            zero_offset_reg <= OFFSET_RESET;
            gain_reg        <= GAIN_RESET;
            sum_reg         <= '0;
            taken_reg       <= '0;
            held_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            avg_count_reg   <= avg_count_next;
            mass_reg        <= mass_next;
            zero_offset_reg <= zero_offset_next;
            gain_reg        <= gain_next;
            sum_reg         <= sum_next;
            taken_reg       <= taken_next;
            held_reg        <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        rdy_reg        <= rdy_next;
        raw_reg        <= raw_next;
        diff_reg       <= diff_next;
        hi_reg         <= hi_next;
        lo_reg         <= lo_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        quo_reg        <= quo_next;
        den_reg        <= den_next;
        cnt_reg        <= cnt_next;
        sign_reg       <= sign_next;
        avg_reg        <= avg_next;
        delta_reg      <= delta_next;
        res_valid_reg  <= res_valid_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    // fresh thrust only ever leaves with the measured status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.thrust_valid |-> out_data.status == STAT_MEASURED)
        else $error("fresh thrust with non-measure status");

    // accumulation count is cleared on completion, so it never reaches the maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg < COUNT_W'(MAX_AVERAGE))
        else $error("sample count out of range");

    // a result moved into the output register frees the input side next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> out_valid_reg && !in_stall)
        else $error("result hand-off failed");

    // the multiplier always runs its full 32 steps before rounding
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MROUND |-> $past(state_reg) == ST_MULT
            && $past(cnt_reg) == STEP_W'(GAIN_W - 1))
        else $error("multiplier cut short");

endmodule

FILE: sim/load_cell_tare_calibrate_scaler_tb.sv
// Self-checking testbench for load_cell_tare_calibrate_scaler: directed and random items,
// results checked in order against a built-in scaler/averager/gain predictor.
// Depends on lcts_pkg and the RTL only.
`timescale 1ns / 1ps

module load_cell_tare_calibrate_scaler_tb;
    import lcts_pkg::*;

    localparam logic signed [79:0] THRUST_HI = 80'sd140737488355327;
    localparam logic signed [79:0] THRUST_LO = -80'sd140737488355328;
    localparam logic signed [79:0] DIFF_LIM  = 80'sd4294967295;
    localparam longint INT32_HI = 64'sd2147483647;
    localparam longint INT32_LO = -64'sd2147483648;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_write = 1'b0;
    logic [1:0]            cfg_index = REG_AVERAGE_COUNT;
    logic [CFG_W-1:0]      cfg_data = '0;

    load_cell_tare_calibrate_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor copy of the block's registers and state
    logic [COUNT_W-1:0]          cfg_count = AVG_COUNT_RESET;
    logic [MASS_W-1:0]           cfg_mass  = MASS_RESET;
    logic signed [OFFSET_W-1:0]  p_offset  = OFFSET_RESET;
    logic signed [GAIN_W-1:0]    p_gain    = GAIN_RESET;
    longint                      p_sum     = 0;
    int unsigned                 p_taken   = 0;
    logic signed [THRUST_W-1:0]  p_held    = '0;

    out_item_t pending_results[$];

    bit quiet = 1'b0;       // no idling on either side
    int hold_left = 0;      // receiver hold-off, in cycles
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int reg_writes = 0;
    int n_measured = 0;
    int n_clipped = 0;
    int n_tare = 0;
    int n_calib = 0;
    int n_zero_delta = 0;

    function automatic logic signed [THRUST_W-1:0] scale_sample(
        logic signed [SAMPLE_BITS-1:0] raw);
        logic signed [79:0] diff;
        logic signed [79:0] prod;
        diff = raw;
        diff = diff * 256 - p_offset;
        if (diff > DIFF_LIM)
            diff = DIFF_LIM;
        else if (diff < -DIFF_LIM)
            diff = -DIFF_LIM;
        prod = diff * p_gain + 80'sd32768;
        prod = prod >>> 16;
        if (prod > THRUST_HI)
        begin
            prod = THRUST_HI;
            n_clipped++;
        end
        else if (prod < THRUST_LO)
        begin
            prod = THRUST_LO;
            n_clipped++;
        end
        return prod[THRUST_W-1:0];
    endfunction

    // Q24.8 mean, nearest with halves away from zero
    function automatic logic signed [OFFSET_W-1:0] mean_q8(longint sum, int unsigned n);
        longint unsigned mag;
        longint unsigned quo;
        longint v;
        mag = (sum < 0) ? -sum : sum;
        mag = mag * 256;
        quo = (mag + n / 2) / n;
        v = (sum < 0) ? -longint'(quo) : longint'(quo);
        if (v > INT32_HI)
            v = INT32_HI;
        else if (v < INT32_LO)
            v = INT32_LO;
        return v[OFFSET_W-1:0];
    endfunction

    // Q8.24 gain = mass * 9.81 / delta, restoring divide, rounded, clamped
    function automatic logic signed [GAIN_W-1:0] gain_for(logic [MASS_W-1:0] mass,
                                                         longint delta);
        longint unsigned num;
        longint unsigned den;
        longint unsigned quo;
        longint unsigned rem;
        bit neg;
        neg = delta < 0;
        num = longint'(mass) * GRAV_NUM;
        den = neg ? -delta : delta;
        den = den * GRAV_DEN;
        quo = 0;
        rem = num;
        if (num >= den)
            quo = 64'd1 << 32;
        else
        begin
            for (int i = 0; i < 32; i++)
            begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    quo = quo | 64'd1;
                end
            end
            if (2 * rem >= den)
                quo++;
        end
        if (neg)
            return (quo > 64'd2147483648) ? 32'sh80000000 : GAIN_W'(-longint'(quo));
        return (quo > 64'd2147483647) ? 32'sh7FFFFFFF : quo[GAIN_W-1:0];
    endfunction

    function automatic out_item_t predict_result(in_item_t item);
        out_item_t res;
        int unsigned n;
        logic signed [OFFSET_W-1:0] avg;
        longint delta;
        n = (cfg_count == 0) ? 1 : ((cfg_count > MAX_AVERAGE) ? MAX_AVERAGE : cfg_count);
        res.thrust_valid = 1'b0;
        res.status = STAT_NOT_READY;
        case (item.op)
            OP_MEASURE:
            begin
                p_sum = 0;
                p_taken = 0;
                if (item.sample_ready)
                begin
                    p_held = scale_sample(item.raw_sample);
                    res.thrust_valid = 1'b1;
                    res.status = STAT_MEASURED;
                    n_measured++;
                end
            end
            OP_TARE, OP_CALIB:
            begin
                if (item.sample_ready)
                begin
                    p_sum = p_sum + item.raw_sample;
                    if (p_sum > INT32_HI)
                        p_sum = INT32_HI;
                    else if (p_sum < INT32_LO)
                        p_sum = INT32_LO;
                    p_taken++;
                    res.status = STAT_AVERAGING;
                    if (p_taken >= n)
                    begin
                        avg = mean_q8(p_sum, n);
                        p_sum = 0;
                        p_taken = 0;
                        if (item.op == OP_TARE)
                        begin
                            p_offset = avg;
                            res.status = STAT_TARE_DONE;
                            n_tare++;
                        end
                        else
                        begin
                            delta = longint'(avg) - longint'(p_offset);
                            if (delta == 0)
                            begin
                                res.status = STAT_ZERO_DELTA;
                                n_zero_delta++;
                            end
                            else
                            begin
                                p_gain = gain_for(cfg_mass, delta);
                                res.status = STAT_CALIBRATED;
                                n_calib++;
                            end
                        end
                    end
                end
            end
            default: ;  // unused op leaves state alone
        endcase
        res.thrust = p_held;
        return res;
    endfunction

    function automatic in_item_t mk(op_t op, logic rdy, int raw);
        in_item_t item;
        item.op = op;
        item.sample_ready = rdy;
        item.raw_sample = SAMPLE_BITS'(raw);
        return item;
    endfunction

    // One input transfer; the expectation is formed at the accepting edge.
    task automatic send_item(in_item_t item);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_result(item));
        items_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(reg_index_t idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_AVERAGE_COUNT: cfg_count = value[COUNT_W-1:0];
            REG_CALIB_MASS:    cfg_mass = value[MASS_W-1:0];
            REG_OFFSET_PRESET: p_offset = value;
            REG_SCALE_PRESET:  p_gain = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    // receiver side: random stalls, plus a counted hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 6);
    end

    always @(posedge clk)
    begin : check_result
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with no transfer pending: thrust %0d status %0d",
                       out_data.thrust, out_data.status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.thrust !== want.thrust)
                begin
                    $error("thrust: expected %0d, got %0d", want.thrust, out_data.thrust);
                    errors++;
                end
                if (out_data.thrust_valid !== want.thrust_valid)
                begin
                    $error("thrust_valid: expected %0d, got %0d",
                           want.thrust_valid, out_data.thrust_valid);
                    errors++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    errors++;
                end
            end
        end
    end

    task automatic test_measure_defaults();
        send_item(mk(OP_MEASURE, 1'b1, 8388607));
        send_item(mk(OP_MEASURE, 1'b1, -8388608));
        send_item(mk(OP_MEASURE, 1'b1, 0));
        send_item(mk(OP_MEASURE, 1'b1, -1));
        send_item(mk(OP_MEASURE, 1'b0, 4242));
        send_item(mk(OP_UNUSED, 1'b1, 123));
        send_item(mk(OP_UNUSED, 1'b0, -5));
        settle();
    endtask

    // count 0 behaves as 1: every ready sample completes an average
    task automatic test_single_sample_average();
        write_register(REG_AVERAGE_COUNT, 0);
        send_item(mk(OP_TARE, 1'b1, 1000));
        send_item(mk(OP_MEASURE, 1'b1, 1000));
        send_item(mk(OP_CALIB, 1'b1, 1000));       // same as offset: skipped
        send_item(mk(OP_CALIB, 1'b1, 1400));
        send_item(mk(OP_MEASURE, 1'b1, 1400));
        settle();
        write_register(REG_CALIB_MASS, 24'hFFFFFF);
        send_item(mk(OP_CALIB, 1'b1, 1001));       // quotient overflows the gain
        send_item(mk(OP_MEASURE, 1'b1, 1002));
        settle();
    endtask

    // tare and calibrate share one accumulation; measure clears it
    task automatic test_mixed_ops();
        write_register(REG_AVERAGE_COUNT, 3);
        write_register(REG_CALIB_MASS, 1000);
        send_item(mk(OP_TARE, 1'b1, 200));
        send_item(mk(OP_TARE, 1'b0, 9999));
        send_item(mk(OP_CALIB, 1'b1, 210));
        send_item(mk(OP_MEASURE, 1'b0, 0));
        send_item(mk(OP_TARE, 1'b1, 300));
        send_item(mk(OP_CALIB, 1'b1, 305));
        send_item(mk(OP_CALIB, 1'b0, 305));
        send_item(mk(OP_CALIB, 1'b1, 310));
        send_item(mk(OP_MEASURE, 1'b1, 320));
        settle();
    endtask

    task automatic test_preset_saturation();
        write_register(REG_OFFSET_PRESET, 32'h80000000);
        write_register(REG_SCALE_PRESET, 32'h7FFFFFFF);
        send_item(mk(OP_MEASURE, 1'b1, 8388607));
        settle();
        write_register(REG_OFFSET_PRESET, 32'h7FFFFFFF);
        send_item(mk(OP_MEASURE, 1'b1, -8388608));
        settle();
        write_register(REG_SCALE_PRESET, 32'h80000000);
        send_item(mk(OP_MEASURE, 1'b1, -8388608));
        settle();
        write_register(REG_OFFSET_PRESET, 0);
        write_register(REG_SCALE_PRESET, GAIN_RESET);
        send_item(mk(OP_MEASURE, 1'b1, 77));
        settle();
    endtask

    // longest averages at full-scale inputs; 511 clamps to the maximum
    task automatic test_long_average();
        write_register(REG_AVERAGE_COUNT, 511);
        for (int i = 0; i < MAX_AVERAGE; i++)
            send_item(mk(OP_TARE, 1'b1, 8388607));
        settle();
        write_register(REG_AVERAGE_COUNT, MAX_AVERAGE);
        for (int i = 0; i < MAX_AVERAGE; i++)
            send_item(mk(OP_CALIB, 1'b1, -8388608));
        send_item(mk(OP_MEASURE, 1'b1, 8388607));
        settle();
    endtask

    // receiver holds off while the sender keeps offering: input must stall
    task automatic test_backpressure();
        hold_left = 300;
        for (int i = 0; i < 24; i++)
            send_item(mk(op_t'($urandom_range(3)), $urandom_range(1), $urandom()));
        settle();
    endtask

    task automatic test_random_sequences();
        int phase;
        int start;
        int n;
        int seq_len;
        int base;
        int delta;
        int spread;
        phase = 0;
        start = items_sent;
        while (items_sent - start < 140)
        begin
            quiet = (phase >= 4 && phase < 9);
            case ($urandom_range(19))
                0:       write_register(REG_AVERAGE_COUNT, 0);
                1:       write_register(REG_AVERAGE_COUNT, MAX_AVERAGE);
                2:       write_register(REG_AVERAGE_COUNT, $urandom_range(257, 511));
                3:       write_register(REG_AVERAGE_COUNT, $urandom_range(9, 24));
                default: write_register(REG_AVERAGE_COUNT, $urandom_range(1, 8));
            endcase
            if ($urandom_range(9) == 0)
                write_register(REG_CALIB_MASS, $urandom() & 32'hFFFFFF);
            else
                write_register(REG_CALIB_MASS, $urandom_range(1, 5000));
            if ($urandom_range(9) < 3)
                write_register(REG_OFFSET_PRESET, $urandom());
            if ($urandom_range(9) < 3)
                write_register(REG_SCALE_PRESET, ($urandom_range(1) != 0) ?
                               $urandom() : $urandom_range(1 << 20, 1 << 26));
            n = (cfg_count == 0) ? 1 : ((cfg_count > MAX_AVERAGE) ? MAX_AVERAGE : cfg_count);
            seq_len = (n > 12) ? $urandom_range(1, 12) : n;
            base = $urandom_range(0, 8000000) - 4000000;
            spread = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 64);
            delta = ($urandom_range(1) != 0) ? $urandom_range(1, 200000)
                                             : -$urandom_range(1, 200000);
            if (spread == 0 && $urandom_range(1) != 0)
                delta = 0;

            for (int i = 0; i < seq_len; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_item(mk(OP_TARE, 1'b0, $urandom()));
                send_item(mk(OP_TARE, 1'b1, base + $urandom_range(0, spread) - spread / 2));
            end
            for (int i = 0; i < 2; i++)
                send_item(mk(OP_MEASURE, 1'b1, base + $urandom_range(0, 2000) - 1000));
            for (int i = 0; i < seq_len; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_item(mk(OP_CALIB, 1'b0, $urandom()));
                send_item(mk(OP_CALIB, 1'b1,
                             base + delta + $urandom_range(0, spread) - spread / 2));
            end
            for (int i = 0; i < 4; i++)
            begin
                if ($urandom_range(1) != 0)
                    send_item(mk(OP_MEASURE, 1'b1, $urandom()));
                else
                    send_item(mk(OP_MEASURE, $urandom_range(1),
                                 base + delta + $urandom_range(0, 4000) - 2000));
            end
            for (int i = 0; i < 3; i++)
                send_item(mk(op_t'($urandom_range(3)), $urandom_range(1), $urandom()));
            settle();
            phase++;
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_measure_defaults();
        test_single_sample_average();
        test_mixed_ops();
        test_preset_saturation();
        test_long_average();
        test_backpressure();
        test_random_sequences();

        settle();
        repeat (100) @(posedge clk);
        $display("Sent %0d items, checked %0d results over %0d register writes.",
                 items_sent, results_seen, reg_writes);
        $display("Measured %0d (%0d clipped), tared %0d, calibrated %0d, zero-delta skips %0d.",
                 n_measured, n_clipped, n_tare, n_calib, n_zero_delta);
        if (errors == 0)
            $display("load_cell_tare_calibrate_scaler test passed");
        else
            $display("load_cell_tare_calibrate_scaler test failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("load_cell_tare_calibrate_scaler test failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/lcts_pkg.sv
hdl/load_cell_tare_calibrate_scaler.sv
sim/load_cell_tare_calibrate_scaler_tb.sv
